/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

endpackage

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and moves it to or from its neighbors.
module spq_cell #(
    parameter int COORD_BITS = 10,
    parameter int COST_BITS  = 16,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                                     i_clk,
    input  spq_pkg::t_cell_op                        i_op,
    input  logic [CNT_W-1:0]                         i_count,
    input  logic [COST_BITS-1:0]                     i_new_cost,
    input  logic [4*COORD_BITS+2*COST_BITS-1:0]      i_new_entry,
    input  logic [4*COORD_BITS+2*COST_BITS-1:0]      i_prev_entry,
    input  logic                                     i_prev_less,
    input  logic [4*COORD_BITS+2*COST_BITS-1:0]      i_next_entry,
    input  logic [4*COORD_BITS+2*COST_BITS-1:0]      i_head_entry,
    output logic [4*COORD_BITS+2*COST_BITS-1:0]      o_entry,
    output logic                                     o_less
);
    import spq_pkg::*;

    localparam int ENTRY_W  = 4*COORD_BITS + 2*COST_BITS;
    localparam int COST_LSB = 4*COORD_BITS;

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;
    logic               w_occupied;
    logic               w_wrap;

    assign w_occupied = (CNT_W'(INDEX) < i_count);
    assign w_wrap     = (i_count == CNT_W'(INDEX + 1));
    // strictly lower cost stays ahead of the new entry
    assign o_less     = w_occupied && (r_entry[COST_LSB +: COST_BITS] < i_new_cost);
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_INSERT: begin
                if (o_less) begin
                    n_entry = r_entry;
                end else if (i_prev_less) begin
                    n_entry = i_new_entry;
                end else begin
                    n_entry = i_prev_entry;
                end
            end
            CELL_POP:    n_entry = i_next_entry;
            CELL_ROTATE: n_entry = w_wrap ? i_head_entry : i_next_entry;
            default:     n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* hdl/spq_out_fifo.sv */
`timescale 1ns / 1ps
// Two-deep result buffer: output register plus skid slot.
module spq_out_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic             r_vld0, r_vld1, n_vld0, n_vld1;
    logic [WIDTH-1:0] r_d0, r_d1, n_d0, n_d1;
    logic             w_pop;

    assign w_pop   = r_vld0 && i_ready;
    assign o_full  = r_vld1;
    assign o_valid = r_vld0;
    assign o_data  = r_d0;

    always_comb begin
        n_vld0 = r_vld0;
        n_vld1 = r_vld1;
        n_d0   = r_d0;
        n_d1   = r_d1;
        if (w_pop) begin
            if (r_vld1) begin
                n_d0   = r_d1;
                n_vld0 = 1'b1;
                n_vld1 = 1'b0;
            end else begin
                n_vld0 = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_vld0) begin
                n_d0   = i_data;
                n_vld0 = 1'b1;
            end else begin
                n_d1   = i_data;
                n_vld1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            r_vld0 <= n_vld0;
            r_vld1 <= n_vld1;
        end
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

/* hdl/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// Sorted priority queue: open list of a grid path search, built as a chain of cells.
//
// Request channel (i_valid / o_ready) carries one operation: insert, pop lowest
// path cost, or lookup by grid point. Every request yields exactly one result on
// the result channel (o_valid / i_ready) with a status and the held entry count.
// Entries sit in a row of QUEUE_DEPTH cells, ordered by path cost from cell 0;
// a new entry goes ahead of equal costs.
// Insert and pop: the row shifts in the accept cycle (insert from its slot on),
//   and the result is pushed into the result buffer in that cycle.
// Lookup: the row rotates once per cycle past cell 0, which compares the point;
//   after N rotations (N = entries held) the order is back and the result is
//   pushed. No request is taken while a lookup scans; a lookup on an empty
//   queue does not scan and pushes its NOT_FOUND result in the accept
//   cycle.
// Results go into a two-deep buffer, so a request is taken while one result
// waits; if the receiver stalls and both slots are full, o_ready drops.
// Reset clears the entry count and the result buffer; cell contents are not
// cleared, since only cells below the count are ever read.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int COORD_BITS  = 10,
    parameter int COST_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  spq_pkg::t_kind                     i_kind,
    input  logic [COORD_BITS-1:0]              i_point_x,
    input  logic [COORD_BITS-1:0]              i_point_y,
    input  logic [COORD_BITS-1:0]              i_pred_x,
    input  logic [COORD_BITS-1:0]              i_pred_y,
    input  logic [COST_BITS-1:0]               i_path_cost,
    input  logic [COST_BITS-1:0]               i_guess_cost,
    output logic                               o_valid,
    input  logic                               i_ready,
    output spq_pkg::t_status                   o_status,
    output logic [COORD_BITS-1:0]              o_out_x,
    output logic [COORD_BITS-1:0]              o_out_y,
    output logic [COORD_BITS-1:0]              o_out_pred_x,
    output logic [COORD_BITS-1:0]              o_out_pred_y,
    output logic [COST_BITS-1:0]               o_out_path_cost,
    output logic [COST_BITS-1:0]               o_out_guess_cost,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_occupancy
);
    import spq_pkg::*;

    localparam int ENTRY_W  = 4*COORD_BITS + 2*COST_BITS;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH+1);
    localparam int STAT_W   = $bits(t_status);
    localparam int RES_W    = STAT_W + ENTRY_W + CNT_W;

    // entry layout: {guess, path, pred_y, pred_x, y, x}
    logic [ENTRY_W-1:0] w_new_entry;
    logic [ENTRY_W-1:0] w_cell_entry [QUEUE_DEPTH];
    logic               w_cell_less  [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] w_head;
    t_cell_op           w_op;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left,  n_left;
    logic               r_found, n_found;
    logic [ENTRY_W-1:0] r_hit,   n_hit;
    logic [COORD_BITS-1:0] r_tx, n_tx, r_ty, n_ty;

    logic               w_accept;
    logic               w_match;
    logic               w_push;
    t_status            w_push_status;
    logic [ENTRY_W-1:0] w_push_entry;
    logic [CNT_W-1:0]   w_push_count;
    logic               w_fifo_full;
    logic [RES_W-1:0]   w_res;

    assign w_new_entry = {i_guess_cost, i_path_cost, i_pred_y, i_pred_x, i_point_y, i_point_x};
    assign w_head      = w_cell_entry[0];
    assign w_match     = (w_head[COORD_BITS-1:0] == r_tx) &&
                         (w_head[2*COORD_BITS-1:COORD_BITS] == r_ty);

    assign o_ready  = (r_state == ST_IDLE) && !w_fifo_full;
    assign w_accept = i_valid && o_ready;

    // cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_prev_entry;
        logic               w_prev_less;
        logic [ENTRY_W-1:0] w_next_entry;

        if (g == 0) begin : g_first
            assign w_prev_entry = w_new_entry;
            assign w_prev_less  = 1'b0;
        end else begin : g_mid
            assign w_prev_entry = w_cell_entry[g-1];
            assign w_prev_less  = w_cell_less[g-1];
        end
        if (g == QUEUE_DEPTH-1) begin : g_last
            assign w_next_entry = w_cell_entry[g];
        end else begin : g_inner
            assign w_next_entry = w_cell_entry[g+1];
        end

        spq_cell #(
            .COORD_BITS (COORD_BITS),
            .COST_BITS  (COST_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_count      (r_count),
            .i_new_cost   (i_path_cost),
            .i_new_entry  (w_new_entry),
            .i_prev_entry (w_prev_entry),
            .i_prev_less  (w_prev_less),
            .i_next_entry (w_next_entry),
            .i_head_entry (w_head),
            .o_entry      (w_cell_entry[g]),
            .o_less       (w_cell_less[g])
        );
    end

    // control: request decode and lookup scan
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_left        = r_left;
        n_found       = r_found;
        n_hit         = r_hit;
        n_tx          = r_tx;
        n_ty          = r_ty;
        w_op          = CELL_HOLD;
        w_push        = 1'b0;
        w_push_status = STATUS_OK;
        w_push_entry  = '0;
        w_push_count  = r_count;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_INSERT: begin
                            w_push = 1'b1;
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                w_push_status = STATUS_FULL;
                            end else begin
                                w_op         = CELL_INSERT;
                                n_count      = r_count + 1'b1;
                                w_push_count = r_count + 1'b1;
                            end
                        end
                        KIND_POP: begin
                            w_push = 1'b1;
                            if (r_count == '0) begin
                                w_push_status = STATUS_EMPTY;
                            end else begin
                                w_op         = CELL_POP;
                                n_count      = r_count - 1'b1;
                                w_push_count = r_count - 1'b1;
                                w_push_entry = w_head;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (r_count == '0) begin
                                w_push        = 1'b1;
                                w_push_status = STATUS_NOT_FOUND;
                            end else begin
                                n_state = ST_SCAN;
                                n_left  = r_count;
                                n_found = 1'b0;
                                n_tx    = i_point_x;
                                n_ty    = i_point_y;
                            end
                        end
                        default: begin
                            w_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // one rotation per cycle; cell 0 holds the next entry in order
                w_op   = CELL_ROTATE;
                n_left = r_left - 1'b1;
                if (!r_found && w_match) begin
                    n_found = 1'b1;
                    n_hit   = w_head;
                end
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                    w_push  = 1'b1;
                    if (r_found) begin
                        w_push_entry = r_hit;
                    end else if (w_match) begin
                        w_push_entry = w_head;
                    end else begin
                        w_push_status = STATUS_NOT_FOUND;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_found <= n_found;
        end
        r_hit <= n_hit;
        r_tx  <= n_tx;
        r_ty  <= n_ty;
    end

    // result buffer
    spq_out_fifo #(
        .WIDTH (RES_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_status, w_push_entry, w_push_count}),
        .o_full  (w_fifo_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_res)
    );

    assign o_status         = t_status'(w_res[RES_W-1 -: STAT_W]);
    assign o_out_x          = w_res[CNT_W +: COORD_BITS];
    assign o_out_y          = w_res[CNT_W + COORD_BITS +: COORD_BITS];
    assign o_out_pred_x     = w_res[CNT_W + 2*COORD_BITS +: COORD_BITS];
    assign o_out_pred_y     = w_res[CNT_W + 3*COORD_BITS +: COORD_BITS];
    assign o_out_path_cost  = w_res[CNT_W + 4*COORD_BITS +: COST_BITS];
    assign o_out_guess_cost = w_res[CNT_W + 4*COORD_BITS + COST_BITS +: COST_BITS];
    assign o_occupancy      = w_res[CNT_W-1:0];

endmodule
